// ----- hw/rtl/wsd_pkg.sv -----
`timescale 1ns / 1ps

package wsd_pkg;

   // Parser phase. Codes beyond the last member fall back to header byte one.
   typedef enum logic [2:0] {
      PH_HDR1    = 3'd0,
      PH_HDR2    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   // Result item kinds
   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // 7-bit length codes that select an extended length field
   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   // Byte counts of the extended length and key fields
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef struct packed {
      logic        item_kind;
      logic        final_fragment;
      logic        reserved_one;
      logic        reserved_two;
      logic        reserved_three;
      logic [3:0]  frame_opcode;
      logic        is_masked;
      logic [31:0] masking_key;
      logic [63:0] frame_length;
      logic [7:0]  payload_byte;
      logic        frame_end;
   } rsp_type;

endpackage

// ----- hw/rtl/wsd_req_if.sv -----
`timescale 1ns / 1ps

interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

// ----- hw/rtl/wsd_rsp_if.sv -----
`timescale 1ns / 1ps

interface wsd_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic        final_fragment;
   logic        reserved_one;
   logic        reserved_two;
   logic        reserved_three;
   logic [3:0]  frame_opcode;
   logic        is_masked;
   logic [31:0] masking_key;
   logic [63:0] frame_length;
   logic [7:0]  payload_byte;
   logic        frame_end;

   modport source (
      output valid, output item_kind, output final_fragment, output reserved_one,
      output reserved_two, output reserved_three, output frame_opcode,
      output is_masked, output masking_key, output frame_length,
      output payload_byte, output frame_end, input ready
   );
   modport sink (
      input valid, input item_kind, input final_fragment, input reserved_one,
      input reserved_two, input reserved_three, input frame_opcode,
      input is_masked, input masking_key, input frame_length,
      input payload_byte, input frame_end, output ready
   );
endinterface

// ----- hw/rtl/websocket_frame_deframer.sv -----
`timescale 1ns / 1ps
// WebSocket (RFC 6455) frame deframer.
// req_chan: one stream byte per beat; frames follow each other with no gap.
// rsp_chan: one header beat per frame on its last header byte (mask key and
//   decoded length included), then one beat per raw payload byte (not
//   unmasked). The last beat of a frame carries frame_end; an empty frame
//   flags its header beat. Payload beats repeat the header fields.
// Header bytes before the last one produce no beat.
// A result is registered; it appears on rsp_chan in the cycle after its byte is taken.
// Throughput: one byte per cycle while the receiver keeps up. The parse state
//   and the output register both update in the accept cycle; the longest path
//   is the 64-bit remaining-count decrement and zero test.
// Stall: the output register holds a beat until taken. req_chan.ready is
//   high whenever that register is empty or is being drained this cycle,
//   so a stalled receiver stalls the stream after one waiting beat.
// Reset (synchronous, active high): parser returns to expecting the first
//   header byte of a new frame, all counters and fields clear, output empty.
module websocket_frame_deframer (
   input logic       clock,
   input logic       reset,
   wsd_req_if.sink   req_chan,
   wsd_rsp_if.source rsp_chan
);
   import wsd_pkg::*;

   phase_type   phase_ff,   phase_in;
   logic [3:0]  count_ff,   count_in;
   logic [7:0]  flags_ff,   flags_in;
   logic        mask_ff,    mask_in;
   logic [63:0] length_ff,  length_in;
   logic [31:0] key_ff,     key_in;
   logic [63:0] remain_ff,  remain_in;

   rsp_type     rsp_ff,     rsp_in;
   logic        rsp_valid_ff;

   logic        take;
   logic        emit;
   logic        frame_end;
   logic        do_after_len;
   logic        do_finish;
   logic [7:0]  b;
   logic [6:0]  len7;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign b              = req_chan.stream_byte;
   assign len7           = b[6:0];

   // Next parse state and result for the byte on the input
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      flags_in     = flags_ff;
      mask_in      = mask_ff;
      length_in    = length_ff;
      key_in       = key_ff;
      remain_in    = remain_ff;
      emit         = 1'b0;
      frame_end    = 1'b0;
      do_after_len = 1'b0;
      do_finish    = 1'b0;
      rsp_in       = '0;
      rsp_in.item_kind = KIND_HEADER;

      case (phase_ff)
         PH_HDR2: begin
            mask_in = b[7];
            key_in  = '0;
            if (len7 < LEN_CODE_16) begin
               length_in    = {57'd0, len7};
               do_after_len = 1'b1;
            end else begin
               length_in = '0;
               count_in  = (len7 == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
               phase_in  = PH_EXTLEN;
            end
         end
         PH_EXTLEN: begin
            length_in = {length_ff[55:0], b};
            count_in  = count_ff - 4'd1;
            if (count_in == 4'd0) begin
               do_after_len = 1'b1;
            end
         end
         PH_KEY: begin
            key_in   = {key_ff[23:0], b};
            count_in = count_ff - 4'd1;
            if (count_in == 4'd0) begin
               do_finish = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            remain_in        = remain_ff - 64'd1;
            emit             = 1'b1;
            rsp_in.item_kind = KIND_PAYLOAD;
            if (remain_in == 64'd0) begin
               frame_end = 1'b1;
               phase_in  = PH_HDR1;
            end
         end
         default: begin
            flags_in  = b;
            mask_in   = 1'b0;
            key_in    = '0;
            length_in = '0;
            count_in  = '0;
            phase_in  = PH_HDR2;
         end
      endcase

      // length known: collect the key or close the header
      if (do_after_len) begin
         if (mask_in) begin
            key_in   = '0;
            count_in = KEY_BYTES;
            phase_in = PH_KEY;
         end else begin
            do_finish = 1'b1;
         end
      end

      if (do_finish) begin
         emit = 1'b1;
         if (length_in == 64'd0) begin
            frame_end = 1'b1;
            phase_in  = PH_HDR1;
         end else begin
            remain_in = length_in;
            phase_in  = PH_PAYLOAD;
         end
      end

      rsp_in.final_fragment = flags_in[7];
      rsp_in.reserved_one   = flags_in[6];
      rsp_in.reserved_two   = flags_in[5];
      rsp_in.reserved_three = flags_in[4];
      rsp_in.frame_opcode   = flags_in[3:0];
      rsp_in.is_masked      = mask_in;
      rsp_in.masking_key    = mask_in ? key_in : 32'd0;
      rsp_in.frame_length   = length_in;
      rsp_in.payload_byte   = (rsp_in.item_kind == KIND_PAYLOAD) ? b : 8'd0;
      rsp_in.frame_end      = frame_end;
   end

   // Parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR1;
         count_ff  <= '0;
         flags_ff  <= '0;
         mask_ff   <= 1'b0;
         length_ff <= '0;
         key_ff    <= '0;
         remain_ff <= '0;
      end else if (take) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         flags_ff  <= flags_in;
         mask_ff   <= mask_in;
         length_ff <= length_in;
         key_ff    <= key_in;
         remain_ff <= remain_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.item_kind      = rsp_ff.item_kind;
   assign rsp_chan.final_fragment = rsp_ff.final_fragment;
   assign rsp_chan.reserved_one   = rsp_ff.reserved_one;
   assign rsp_chan.reserved_two   = rsp_ff.reserved_two;
   assign rsp_chan.reserved_three = rsp_ff.reserved_three;
   assign rsp_chan.frame_opcode   = rsp_ff.frame_opcode;
   assign rsp_chan.is_masked      = rsp_ff.is_masked;
   assign rsp_chan.masking_key    = rsp_ff.masking_key;
   assign rsp_chan.frame_length   = rsp_ff.frame_length;
   assign rsp_chan.payload_byte   = rsp_ff.payload_byte;
   assign rsp_chan.frame_end      = rsp_ff.frame_end;

   // In payload there is always at least one byte left to come
   a_payload_remain: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remain_ff != 64'd0))
      else $error("payload phase with zero bytes remaining");

   // Field collection phases always have bytes outstanding
   a_field_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_EXTLEN || phase_ff == PH_KEY) |-> (count_ff != 4'd0))
      else $error("field phase with zero byte count");

   // A header beat that closes its frame belongs to an empty frame
   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.item_kind == KIND_HEADER && rsp_ff.frame_end)
      |-> (rsp_ff.frame_length == 64'd0))
      else $error("header beat flagged frame_end with nonzero length");

   // After the byte that ends a frame is taken, the parser waits for a new header
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (take && emit && frame_end) |=> (phase_ff == PH_HDR1))
      else $error("parser did not restart after frame end");

endmodule
